/* hdl/ccs_pkg.sv */
// ----------------------------------------------------------------------------
// ccs_pkg
// Types, codes and helpers for the charge connector session controller.
// ----------------------------------------------------------------------------
package ccs_pkg;

  localparam logic [2:0] ST_DISC    = 3'd0;
  localparam logic [2:0] ST_NOKEY   = 3'd1;
  localparam logic [2:0] ST_NOALLOC = 3'd2;
  localparam logic [2:0] ST_RUN     = 3'd3;
  localparam logic [2:0] ST_DONE    = 3'd4;

  localparam logic [2:0] CMD_CONNECT    = 3'd0;
  localparam logic [2:0] CMD_DISCONNECT = 3'd1;
  localparam logic [2:0] CMD_PHASE      = 3'd2;
  localparam logic [2:0] CMD_ALLOC      = 3'd3;
  localparam logic [2:0] CMD_KEY        = 3'd4;
  localparam logic [2:0] CMD_TICK       = 3'd5;
  localparam logic [2:0] CMD_SETPOINT   = 3'd6;

  localparam logic [2:0] PH_OFF         = 3'd0;
  localparam logic [2:0] PH_EXPORT_CC   = 3'd1;
  localparam logic [2:0] PH_OFF_CC      = 3'd2;
  localparam logic [2:0] PH_PRECHARGE   = 3'd3;
  localparam logic [2:0] PH_CHARGING    = 3'd4;

  localparam logic [2:0] WS_STANDBY     = 3'd0;
  localparam logic [2:0] WS_PLUGGED     = 3'd1;
  localparam logic [2:0] WS_STARTING    = 3'd2;
  localparam logic [2:0] WS_CHARGING    = 3'd3;
  localparam logic [2:0] WS_COMPLETE    = 3'd4;

  localparam logic [1:0] EV_NONE        = 2'd0;
  localparam logic [1:0] EV_STOP_START  = 2'd1;
  localparam logic [1:0] EV_START_STOP  = 2'd2;

  localparam logic [2:0] FR_NONE        = 3'd0;
  localparam logic [2:0] FR_STOP        = 3'd1;
  localparam logic [2:0] FR_ALLOC       = 3'd2;
  localparam logic [2:0] FR_INS_OUTPUT  = 3'd3;
  localparam logic [2:0] FR_INS_STOP    = 3'd4;
  localparam logic [2:0] FR_PRECHARGE   = 3'd5;
  localparam logic [2:0] FR_CHARGING    = 3'd6;

  localparam logic [14:0] VOLT_MAX = 15'd20000;
  localparam logic [13:0] CURR_MAX = 14'd10000;

  localparam logic REG_ALLOC_TIMEOUT = 1'b0;
  localparam logic REG_CONNECTOR_ID  = 1'b1;
  localparam logic [15:0] ALLOC_TIMEOUT_RESET = 16'd1000;

  typedef struct packed {
    logic [2:0]  command;
    logic [2:0]  new_phase;
    logic        alloc_success;
    logic [14:0] set_voltage;
    logic [13:0] set_current;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  session_state_out;
    logic [2:0]  phase_out;
    logic [2:0]  charge_status;
    logic        plugged;
    logic [1:0]  event_report;
    logic [2:0]  frame_kind;
    logic [15:0] frame_connector;
    logic [14:0] frame_voltage;
    logic [13:0] frame_current;
    logic        alloc_failed;
  } out_item_t;

  function automatic logic [2:0] work_status(input logic [2:0] st, input logic [2:0] ph);
    logic [2:0] ws;
    unique case (st)
      ST_DISC:    ws = WS_STANDBY;
      ST_NOKEY:   ws = WS_PLUGGED;
      ST_NOALLOC: ws = WS_STARTING;
      ST_RUN:     ws = (ph == PH_CHARGING) ? WS_CHARGING : WS_STARTING;
      default:    ws = WS_COMPLETE;
    endcase
    return ws;
  endfunction

  function automatic logic [2:0] frame_for(input logic [2:0] st, input logic [2:0] ph);
    logic [2:0] fk;
    if (st == ST_NOALLOC) begin
      fk = FR_ALLOC;
    end else if (st == ST_RUN) begin
      unique case (ph)
        PH_OFF:       fk = FR_ALLOC;
        PH_EXPORT_CC: fk = FR_INS_OUTPUT;
        PH_OFF_CC:    fk = FR_INS_STOP;
        PH_PRECHARGE: fk = FR_PRECHARGE;
        default:      fk = FR_CHARGING;
      endcase
    end else begin
      fk = FR_STOP;
    end
    return fk;
  endfunction

endpackage

/* hdl/ccs_in_if.sv */
// ----------------------------------------------------------------------------
// ccs_in_if
// Valid/ready channel carrying one session event per transaction.
// ----------------------------------------------------------------------------
interface ccs_in_if;
  logic               valid;
  logic               ready;
  ccs_pkg::in_item_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* hdl/ccs_out_if.sv */
// ----------------------------------------------------------------------------
// ccs_out_if
// Valid/ready channel carrying one session result per transaction.
// ----------------------------------------------------------------------------
interface ccs_out_if;
  logic               valid;
  logic               ready;
  ccs_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* hdl/charge_connector_session_fsm.sv */
// ----------------------------------------------------------------------------
// charge_connector_session_fsm
// Session controller for one DC charging connector: session state, mode
// phase, setpoints, allocation timeout and power-supply frame selection.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake              | payload
//  in_ch    | sink      | valid/ready            | command, phase, setpoints
//  out_ch   | source    | valid/ready            | status, report, frame
//  cfg_*    | slave     | APB, pready tied high  | timeout, connector id
//
//  An event is held in an input register, then resolved into the result
//  register while the session state updates: one transaction per cycle
//  while the result is taken or absent. Input and result registers are
//  separate, so an empty input register takes an event while a result
//  waits. Reset is synchronous; the timeout register returns to 1000 ticks.
// ----------------------------------------------------------------------------
module charge_connector_session_fsm (
  input  logic         clk,
  input  logic         rst_n,
  ccs_in_if.sink       in_ch,
  ccs_out_if.source    out_ch,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [2:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  logic [15:0] alloc_timeout_r;
  logic [15:0] connector_id_r;

  logic                in_valid_r;
  ccs_pkg::in_item_t   in_item_r;
  logic                out_valid_r;
  ccs_pkg::out_item_t  out_item_r;
  ccs_pkg::out_item_t  out_item_nxt;

  logic [2:0]  state_r, state_nxt;
  logic [2:0]  phase_r, phase_nxt;
  logic        failed_r, failed_nxt;
  logic [15:0] wait_r, wait_nxt;
  logic [14:0] volt_r, volt_nxt;
  logic [13:0] curr_r, curr_nxt;

  logic advance;
  logic cfg_wr;

  assign advance     = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !in_valid_r || advance;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_item_r;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_prdata = (cfg_paddr[2] == ccs_pkg::REG_CONNECTOR_ID) ?
                      {16'd0, connector_id_r} : {16'd0, alloc_timeout_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alloc_timeout_r <= ccs_pkg::ALLOC_TIMEOUT_RESET;
      connector_id_r  <= 16'd0;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == ccs_pkg::REG_CONNECTOR_ID) begin
        connector_id_r <= cfg_pwdata[15:0];
      end else begin
        alloc_timeout_r <= cfg_pwdata[15:0];
      end
    end
  end

  always_comb begin
    logic [15:0] wait_inc;
    logic        st_chg;
    logic        send;
    logic [2:0]  kind;
    state_nxt  = state_r;
    phase_nxt  = phase_r;
    failed_nxt = failed_r;
    wait_nxt   = wait_r;
    volt_nxt   = volt_r;
    curr_nxt   = curr_r;
    send       = 1'b0;
    wait_inc   = wait_r + 16'd1;
    unique case (in_item_r.command)
      ccs_pkg::CMD_CONNECT: begin
        if (state_r == ccs_pkg::ST_DISC) state_nxt = ccs_pkg::ST_NOKEY;
      end
      ccs_pkg::CMD_DISCONNECT: begin
        if (state_r != ccs_pkg::ST_DISC) state_nxt = ccs_pkg::ST_DISC;
      end
      ccs_pkg::CMD_PHASE: begin
        if (in_item_r.new_phase <= ccs_pkg::PH_CHARGING) begin
          phase_nxt = in_item_r.new_phase;
          if (state_r == ccs_pkg::ST_RUN && in_item_r.new_phase == ccs_pkg::PH_OFF) begin
            state_nxt = ccs_pkg::ST_DONE;
          end else if (state_r == ccs_pkg::ST_DONE &&
                       (in_item_r.new_phase == ccs_pkg::PH_EXPORT_CC ||
                        in_item_r.new_phase == ccs_pkg::PH_PRECHARGE ||
                        in_item_r.new_phase == ccs_pkg::PH_CHARGING)) begin
            state_nxt = ccs_pkg::ST_NOKEY;
          end
        end
      end
      ccs_pkg::CMD_ALLOC: begin
        if (state_r == ccs_pkg::ST_NOALLOC) begin
          failed_nxt = !in_item_r.alloc_success;
          state_nxt  = ccs_pkg::ST_RUN;
        end
      end
      ccs_pkg::CMD_KEY: begin
        if (state_r == ccs_pkg::ST_NOKEY) state_nxt = ccs_pkg::ST_NOALLOC;
      end
      ccs_pkg::CMD_TICK: begin
        if (state_r == ccs_pkg::ST_NOALLOC) begin
          wait_nxt = wait_inc;
          if (wait_inc >= alloc_timeout_r) begin
            failed_nxt = 1'b1;
            state_nxt  = ccs_pkg::ST_RUN;
          end
        end
      end
      ccs_pkg::CMD_SETPOINT: begin
        volt_nxt = (in_item_r.set_voltage > ccs_pkg::VOLT_MAX) ?
                   ccs_pkg::VOLT_MAX : in_item_r.set_voltage;
        curr_nxt = (in_item_r.set_current > ccs_pkg::CURR_MAX) ?
                   ccs_pkg::CURR_MAX : in_item_r.set_current;
        if (state_r == ccs_pkg::ST_RUN) send = 1'b1;
      end
      default: begin
      end
    endcase

    st_chg = (state_nxt != state_r);
    if (st_chg) begin
      if (state_nxt == ccs_pkg::ST_NOALLOC) wait_nxt = 16'd0;
      if (state_nxt != ccs_pkg::ST_RUN) failed_nxt = 1'b0;
    end
    if (st_chg || (phase_nxt != phase_r)) send = 1'b1;
    kind = send ? ccs_pkg::frame_for(state_nxt, phase_nxt) : ccs_pkg::FR_NONE;

    out_item_nxt.session_state_out = state_nxt;
    out_item_nxt.phase_out         = phase_nxt;
    out_item_nxt.charge_status     = ccs_pkg::work_status(state_nxt, phase_nxt);
    out_item_nxt.plugged           = (state_nxt != ccs_pkg::ST_DISC);
    out_item_nxt.event_report      = !st_chg ? ccs_pkg::EV_NONE :
                                     (state_nxt == ccs_pkg::ST_RUN) ?
                                     ccs_pkg::EV_STOP_START : ccs_pkg::EV_START_STOP;
    out_item_nxt.frame_kind        = kind;
    out_item_nxt.frame_connector   = (kind != ccs_pkg::FR_NONE) ? connector_id_r : 16'd0;
    if (kind == ccs_pkg::FR_INS_OUTPUT || kind == ccs_pkg::FR_PRECHARGE ||
        kind == ccs_pkg::FR_CHARGING) begin
      out_item_nxt.frame_voltage = volt_nxt;
      out_item_nxt.frame_current = curr_nxt;
    end else begin
      out_item_nxt.frame_voltage = 15'd0;
      out_item_nxt.frame_current = 14'd0;
    end
    out_item_nxt.alloc_failed = failed_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= ccs_pkg::ST_DISC;
      phase_r     <= ccs_pkg::PH_OFF;
      failed_r    <= 1'b0;
      wait_r      <= 16'd0;
      volt_r      <= 15'd0;
      curr_r      <= 14'd0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        in_valid_r <= 1'b1;
      end else if (advance) begin
        in_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        state_r     <= state_nxt;
        phase_r     <= phase_nxt;
        failed_r    <= failed_nxt;
        wait_r      <= wait_nxt;
        volt_r      <= volt_nxt;
        curr_r      <= curr_nxt;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) in_item_r <= in_ch.data;
    if (advance) out_item_r <= out_item_nxt;
  end

endmodule
